// ===== hdl/dmmh_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual multiply-mix hash package
// Widths, microcode field codes, the control word layout and the microcode
// table that drives the shared multiply-mix datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dmmh_pkg;

    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int STEP_W      = 4;

    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [STEP_W-1:0]      step_t;

    localparam cfg_index_t REG_SEED_LOW  = 1'd0;
    localparam cfg_index_t REG_SEED_HIGH = 1'd1;

    // Multiplier operand source.
    localparam logic [1:0] Y_X     = 2'd0;
    localparam logic [1:0] Y_W0_SC = 2'd1;
    localparam logic [1:0] Y_W0_RC = 2'd2;
    localparam logic [1:0] Y_W1_X  = 2'd3;

    // Full-width coefficient source.
    localparam logic [1:0] KM_CONST     = 2'd0;
    localparam logic [1:0] KM_SEED_LOW  = 2'd1;
    localparam logic [1:0] KM_SEED_HIGH = 2'd2;

    // Combination of the two products.
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SUB  = 2'd1;
    localparam logic [1:0] OP_RSUB = 2'd2;

    // Result destination.
    localparam logic [2:0] D_X          = 3'd0;
    localparam logic [2:0] D_X_ACC_SWAP = 3'd1;
    localparam logic [2:0] D_X_ACC_REV  = 3'd2;
    localparam logic [2:0] D_SWAP       = 3'd3;
    localparam logic [2:0] D_REV        = 3'd4;

    // Sequencing.
    localparam logic SEQ_NEXT = 1'b0;
    localparam logic SEQ_END  = 1'b1;

    typedef struct packed {
        logic [1:0] ysel;
        logic [1:0] kmode;
        word_t      k1;
        word_t      k2;
        logic [1:0] op;
        logic [2:0] dest;
        logic       seq;
    } uword_t;

    typedef struct packed {
        logic   load;
        logic   step_en;
        uword_t uw;
    } dmmh_ctrl_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } dmmh_status_t;

    function automatic uword_t mk_uword(input logic [1:0] ysel, input logic [1:0] kmode,
                                        input word_t k1, input word_t k2,
                                        input logic [1:0] op, input logic [2:0] dest,
                                        input logic seq);
        uword_t w;
        w.ysel  = ysel;
        w.kmode = kmode;
        w.k1    = k1;
        w.k2    = k2;
        w.op    = op;
        w.dest  = dest;
        w.seq   = seq;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        unique case (step)
            4'd0:  w = mk_uword(Y_W0_SC, KM_SEED_LOW, 32'h69FB0000, 32'h10FA9605,
                                OP_SUB, D_X, SEQ_NEXT);
            4'd1:  w = mk_uword(Y_X, KM_CONST, 32'h79F8A395, 32'h689B6B9F,
                                OP_ADD, D_X, SEQ_NEXT);
            4'd2:  w = mk_uword(Y_X, KM_CONST, 32'hEA970001, 32'h3C101569,
                                OP_SUB, D_X_ACC_SWAP, SEQ_NEXT);
            4'd3:  w = mk_uword(Y_W1_X, KM_SEED_HIGH, 32'h13DB0000, 32'h3CE8EC25,
                                OP_SUB, D_X, SEQ_NEXT);
            4'd4:  w = mk_uword(Y_X, KM_CONST, 32'h59C3AF2D, 32'h2232E0F1,
                                OP_SUB, D_X, SEQ_NEXT);
            4'd5:  w = mk_uword(Y_X, KM_CONST, 32'h1EC90001, 32'h35BD1EC9,
                                OP_ADD, D_SWAP, SEQ_NEXT);
            4'd6:  w = mk_uword(Y_W0_RC, KM_SEED_LOW, 32'h00000000, 32'h00000000,
                                OP_ADD, D_X, SEQ_NEXT);
            4'd7:  w = mk_uword(Y_X, KM_CONST, 32'hB1110000, 32'h30674EEF,
                                OP_SUB, D_X, SEQ_NEXT);
            4'd8:  w = mk_uword(Y_X, KM_CONST, 32'h5B9F0000, 32'h78F7A461,
                                OP_SUB, D_X, SEQ_NEXT);
            4'd9:  w = mk_uword(Y_X, KM_CONST, 32'h46930000, 32'h12CEB96D,
                                OP_RSUB, D_X, SEQ_NEXT);
            4'd10: w = mk_uword(Y_X, KM_CONST, 32'h1D830000, 32'h257E1D83,
                                OP_ADD, D_X_ACC_REV, SEQ_NEXT);
            4'd11: w = mk_uword(Y_W1_X, KM_SEED_HIGH, 32'h00000000, 32'h00000000,
                                OP_ADD, D_X, SEQ_NEXT);
            4'd12: w = mk_uword(Y_X, KM_CONST, 32'h16F50000, 32'h5D8BE90B,
                                OP_SUB, D_X, SEQ_NEXT);
            4'd13: w = mk_uword(Y_X, KM_CONST, 32'h96FF0000, 32'h2C7C6901,
                                OP_SUB, D_X, SEQ_NEXT);
            4'd14: w = mk_uword(Y_X, KM_CONST, 32'h2B890000, 32'h7C932B89,
                                OP_ADD, D_X, SEQ_NEXT);
            4'd15: w = mk_uword(Y_X, KM_CONST, 32'h9F690000, 32'h405B6097,
                                OP_SUB, D_REV, SEQ_END);
            default: w = mk_uword(Y_X, KM_CONST, 32'h00000000, 32'h00000000,
                                  OP_ADD, D_X, SEQ_END);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dmmh_msg_if.sv =====
// ----------------------------------------------------------------------------
// Message word-pair channel
// Valid/ready channel carrying one pair of message words and the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmmh_msg_if
    import dmmh_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t word_even;
    word_t word_odd;
    logic  last_pair;

    modport source (output valid, output word_even, output word_odd, output last_pair,
                    input ready);
    modport sink (input valid, input word_even, input word_odd, input last_pair,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/dmmh_hash_if.sv =====
// ----------------------------------------------------------------------------
// Hash result channel
// Valid/ready channel carrying one 64-bit hash as two 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmmh_hash_if
    import dmmh_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t hash_low;
    word_t hash_high;

    modport source (output valid, output hash_low, output hash_high, input ready);
    modport sink (input valid, input hash_low, input hash_high, output ready);
endinterface

`default_nettype wire

// ===== hdl/dmmh_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmmh_cfg_if
    import dmmh_pkg::*;
;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    word_t      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/dmmh_useq.sv =====
// ----------------------------------------------------------------------------
// Dual multiply-mix hash microsequencer
// Step counter over the microcode table, with the end-of-pair branch that
// returns to idle, stalling on a last pair while a hash still awaits transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module dmmh_useq
    import dmmh_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         msg_valid,
    output logic              msg_ready,
    input  wire dmmh_status_t status,
    output dmmh_ctrl_t        ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic   state_reg;
    logic   state_next;
    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   stall;

    always_comb
    begin
        uw           = ucode_rom(step_reg);
        stall        = (uw.seq == SEQ_END) && status.last && status.out_busy;
        msg_ready    = (state_reg == ST_IDLE);
        ctrl.load    = msg_valid && msg_ready;
        ctrl.step_en = (state_reg == ST_RUN) && !stall;
        ctrl.uw      = uw;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.load)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (ctrl.step_en)
                begin
                    if (uw.seq == SEQ_END)
                    begin
                        state_next = ST_IDLE;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + step_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_load_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (state_reg == ST_RUN && step_reg == '0))
        else $error("pair transfer did not start the program at its first step");

    a_idle_at_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_reg == '0))
        else $error("step counter not at zero while idle");

    a_stall_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && stall) |=> (state_reg == ST_RUN && $stable(step_reg)))
        else $error("sequencer moved on while the hash register was occupied");

endmodule

`default_nettype wire

// ===== hdl/dmmh_datapath.sv =====
// ----------------------------------------------------------------------------
// Dual multiply-mix hash datapath
// Seed registers, chain state, a shared full multiplier and half multiplier
// with add/subtract, and the registered hash output.
// ----------------------------------------------------------------------------
`default_nettype none

module dmmh_datapath
    import dmmh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    dmmh_cfg_if.sink        cfg,
    dmmh_hash_if.source     hash,
    input  wire word_t      word_even,
    input  wire word_t      word_odd,
    input  wire logic       last_pair,
    input  wire dmmh_ctrl_t ctrl,
    output dmmh_status_t    status
);

    word_t seed_low_reg;
    word_t seed_high_reg;
    word_t swap_carry_reg;
    word_t swap_sum_reg;
    word_t rev_carry_reg;
    word_t rev_sum_reg;
    word_t w0_reg;
    word_t w1_reg;
    logic  last_reg;
    word_t x_reg;
    word_t acc_reg;
    word_t hash_low_reg;
    word_t hash_high_reg;
    logic  out_valid_reg;

    word_t k1_eff;
    word_t y;
    word_t prod1;
    word_t prod2;
    word_t res;
    word_t chain_sum;
    logic  emit;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        case (ctrl.uw.kmode)
            KM_SEED_LOW:  k1_eff = {seed_low_reg[WORD_W-1:1], 1'b1} + ctrl.uw.k1;
            KM_SEED_HIGH: k1_eff = {seed_high_reg[WORD_W-1:1], 1'b1} + ctrl.uw.k1;
            default:      k1_eff = ctrl.uw.k1;
        endcase

        case (ctrl.uw.ysel)
            Y_W0_SC: y = w0_reg + swap_carry_reg;
            Y_W0_RC: y = w0_reg + rev_carry_reg;
            Y_W1_X:  y = w1_reg + x_reg;
            default: y = x_reg;
        endcase

        prod1 = k1_eff * y;
        prod2 = ctrl.uw.k2 * {{(WORD_W-HALF_W){1'b0}}, y[WORD_W-1:HALF_W]};

        case (ctrl.uw.op)
            OP_SUB:  res = prod1 - prod2;
            OP_RSUB: res = prod2 - prod1;
            default: res = prod1 + prod2;
        endcase

        chain_sum = res + acc_reg;
        emit      = ctrl.step_en && (ctrl.uw.seq == SEQ_END) && last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_low_reg  <= '0;
            seed_high_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_SEED_LOW:  seed_low_reg  <= cfg.data;
                REG_SEED_HIGH: seed_high_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_carry_reg <= '0;
            swap_sum_reg   <= '0;
            rev_carry_reg  <= '0;
            rev_sum_reg    <= '0;
        end
        else if (emit)
        begin
            swap_carry_reg <= '0;
            swap_sum_reg   <= '0;
            rev_carry_reg  <= '0;
            rev_sum_reg    <= '0;
        end
        else if (ctrl.step_en)
        begin
            if (ctrl.uw.dest == D_SWAP)
            begin
                swap_carry_reg <= res;
                swap_sum_reg   <= chain_sum;
            end
            if (ctrl.uw.dest == D_REV)
            begin
                rev_carry_reg <= res;
                rev_sum_reg   <= chain_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            w0_reg   <= word_even;
            w1_reg   <= word_odd;
            last_reg <= last_pair;
        end
        if (ctrl.step_en)
        begin
            x_reg <= res;
            if (ctrl.uw.dest == D_X_ACC_SWAP)
            begin
                acc_reg <= res + swap_sum_reg;
            end
            else if (ctrl.uw.dest == D_X_ACC_REV)
            begin
                acc_reg <= res + rev_sum_reg;
            end
        end
        if (emit)
        begin
            hash_low_reg  <= swap_carry_reg ^ res;
            hash_high_reg <= swap_sum_reg ^ chain_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (hash.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign hash.valid      = out_valid_reg;
    assign hash.hash_low   = hash_low_reg;
    assign hash.hash_high  = hash_high_reg;
    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg && !hash.ready;

    a_emit_into_free_register: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(out_valid_reg && !hash.ready))
        else $error("hash produced while the previous one was still waiting");

    a_emit_clears_chains: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (hash.valid && swap_carry_reg == '0 && swap_sum_reg == '0
                  && rev_carry_reg == '0 && rev_sum_reg == '0))
        else $error("chain state not cleared after the final pair");

endmodule

`default_nettype wire

// ===== hdl/dual_multiply_mix_hash.sv =====
// ----------------------------------------------------------------------------
// Dual multiply-mix hash
// Keyed 64-bit hash over 32-bit word pairs, run by a microcoded sequencer
// over a shared multiply-mix datapath for the word-swap and reversible chains.
// ----------------------------------------------------------------------------
// A pair is taken while the sequencer is idle and then runs 16 microcode
// steps, one multiply-mix round per cycle through the shared multiplier pair
// unless stalled; no new pair is taken before the final step. The hash is
// valid in the output register in the cycle after the final step of the last pair.
// A last pair's final step waits while an earlier hash still awaits its transfer.
// Reset clears the seeds, all chain state and the output valid flag.
`default_nettype none

module dual_multiply_mix_hash
    import dmmh_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dmmh_msg_if.sink    msg,
    dmmh_hash_if.source hash,
    dmmh_cfg_if.sink    cfg
);

    dmmh_ctrl_t   ctrl;
    dmmh_status_t status;

    dmmh_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg.valid),
        .msg_ready (msg.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    dmmh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .hash      (hash),
        .word_even (msg.word_even),
        .word_odd  (msg.word_odd),
        .last_pair (msg.last_pair),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== tb/dual_multiply_mix_hash_test.sv =====
// ----------------------------------------------------------------------------
// Dual multiply-mix hash testbench
// Feeds word pairs grouped into messages under several seed settings and
// idling patterns, predicts each 64-bit hash from its own model of the two
// mixing chains and compares every hash transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_multiply_mix_hash_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmmh_pkg::*;

    class hash_checker;
        word_t seed_lo;
        word_t seed_hi;
        word_t swap_carry;
        word_t swap_sum;
        word_t rev_carry;
        word_t rev_sum;
        word_t due_low[$];
        word_t due_high[$];
        int    errors;

        function new();
            seed_lo = '0;
            seed_hi = '0;
            errors  = 0;
            clear_chains();
        endfunction

        function void clear_chains();
            swap_carry = '0;
            swap_sum   = '0;
            rev_carry  = '0;
            rev_sum    = '0;
        endfunction

        function void write_seed(cfg_index_t idx, word_t value);
            if (idx == REG_SEED_LOW)
                seed_lo = value;
            else if (idx == REG_SEED_HIGH)
                seed_hi = value;
        endfunction

        function void take_pair(word_t w0, word_t w1, logic last);
            word_t m0, m1, k0, k1, a, t, u, v, acc, b, r, s;
            word_t p, q, x, c, d, e, f;
            m0 = seed_lo | 32'd1;
            m1 = seed_hi | 32'd1;

            // Word-swap chain.
            k0  = m0 + 32'h69FB0000;
            k1  = m1 + 32'h13DB0000;
            a   = w0 + swap_carry;
            t   = a * k0 - 32'h10FA9605 * (a >> 16);
            u   = 32'h79F8A395 * t + 32'h689B6B9F * (t >> 16);
            v   = 32'hEA970001 * u - 32'h3C101569 * (u >> 16);
            acc = v + swap_sum;
            b   = w1 + v;
            r   = b * k1 - 32'h3CE8EC25 * (b >> 16);
            s   = 32'h59C3AF2D * r - 32'h2232E0F1 * (r >> 16);
            swap_carry = 32'h1EC90001 * s + 32'h35BD1EC9 * (s >> 16);
            swap_sum   = swap_carry + acc;

            // Reversible chain.
            a   = m0 * (w0 + rev_carry);
            p   = 32'hB1110000 * a - 32'h30674EEF * (a >> 16);
            q   = 32'h5B9F0000 * p - 32'h78F7A461 * (p >> 16);
            x   = 32'h12CEB96D * (q >> 16) - 32'h46930000 * q;
            v   = 32'h1D830000 * x + 32'h257E1D83 * (x >> 16);
            acc = v + rev_sum;
            c   = m1 * (w1 + v);
            d   = 32'h16F50000 * c - 32'h5D8BE90B * (c >> 16);
            e   = 32'h96FF0000 * d - 32'h2C7C6901 * (d >> 16);
            f   = 32'h2B890000 * e + 32'h7C932B89 * (e >> 16);
            rev_carry = 32'h9F690000 * f - 32'h405B6097 * (f >> 16);
            rev_sum   = rev_carry + acc;

            if (last)
            begin
                due_low.push_back(swap_carry ^ rev_carry);
                due_high.push_back(swap_sum ^ rev_sum);
                clear_chains();
            end
        endfunction

        function void check_hash(word_t got_low, word_t got_high);
            word_t want_low, want_high;
            if (due_low.size() == 0)
            begin
                $error("hash transfer with no hash due: low %08h, high %08h",
                       got_low, got_high);
                errors++;
                return;
            end
            want_low  = due_low.pop_front();
            want_high = due_high.pop_front();
            if (got_low !== want_low)
            begin
                $error("hash_low: expected %08h, actual %08h", want_low, got_low);
                errors++;
            end
            if (got_high !== want_high)
            begin
                $error("hash_high: expected %08h, actual %08h", want_high, got_high);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_low.size();
        endfunction
    endclass

    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_PAIRS   = 400;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;

    int send_pcts[4] = '{0, 72, 0, 19};
    int recv_pcts[4] = '{0, 0, 72, 19};

    hash_checker sb = new();

    dmmh_msg_if  msg_ch ();
    dmmh_hash_if hash_ch ();
    dmmh_cfg_if  cfg_ch ();

    dual_multiply_mix_hash dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .hash  (hash_ch),
        .cfg   (cfg_ch)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        hash_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_seed(cfg_ch.index, cfg_ch.data);
            if (hash_ch.valid && hash_ch.ready)
                sb.check_hash(hash_ch.hash_low, hash_ch.hash_high);
            if (msg_ch.valid && msg_ch.ready)
                sb.take_pair(msg_ch.word_even, msg_ch.word_odd, msg_ch.last_pair);
        end
    end

    task automatic send_pair(input word_t w0, input word_t w1, input logic last);
        int gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.word_even <= w0;
        msg_ch.word_odd  <= w1;
        msg_ch.last_pair <= last;
        do
            @(posedge clk);
        while (!msg_ch.ready);
    endtask

    // Lets the block finish its work, including pairs that yield no hash.
    task automatic drain();
        msg_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seeds(input bit set_low, input word_t low,
                               input bit set_high, input word_t high);
        if (set_low)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= REG_SEED_LOW;
            cfg_ch.data  <= low;
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        if (set_high)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= REG_SEED_HIGH;
            cfg_ch.data  <= high;
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(31);
            3:       return ~(word_t'(1) << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int sent;
        int len;
        clk            = 1'b0;
        rst_n          <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        msg_ch.valid     <= 1'b0;
        msg_ch.word_even <= '0;
        msg_ch.word_odd  <= '0;
        msg_ch.last_pair <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_SEED_LOW;
        cfg_ch.data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Seeds at their reset value, single-pair and multi-pair messages.
        send_pair(32'h00000000, 32'h00000000, 1'b1);
        send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
        send_pair(32'hFFFFFFFF, 32'h00000000, 1'b1);
        send_pair(32'h00000000, 32'hFFFFFFFF, 1'b1);
        send_pair(32'hAAAAAAAA, 32'h55555555, 1'b0);
        send_pair(32'h55555555, 32'hAAAAAAAA, 1'b0);
        send_pair(32'h80000000, 32'h00000001, 1'b0);
        send_pair(32'h00000001, 32'h80000000, 1'b1);
        drain();

        // Even seeds, which the block must treat as odd.
        write_seeds(1'b1, 32'hFFFFFFFE, 1'b1, 32'hFFFFFFFE);
        send_pair(32'h12345678, 32'h9ABCDEF0, 1'b1);
        send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);

        // Seeds changed part-way through a message.
        send_pair(32'h00000000, 32'h00000000, 1'b0);
        drain();
        write_seeds(1'b1, 32'h00000000, 1'b0, '0);
        send_pair(32'h00000000, 32'h00000000, 1'b1);
        send_pair(32'hDEADBEEF, 32'h00000000, 1'b0);
        drain();
        write_seeds(1'b0, '0, 1'b1, 32'h80000000);
        send_pair(32'h00000000, 32'hCAFEF00D, 1'b1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            case (phase)
                0:       write_seeds(1'b1, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
                1:       write_seeds(1'b1, 32'h00000000, 1'b1, 32'h00000000);
                2:       write_seeds(1'b1, $urandom, 1'b1, $urandom);
                default: write_seeds(1'b1, $urandom, 1'b1, 32'hFFFFFFFE);
            endcase
            sent = 0;
            while (sent < PHASE_PAIRS)
            begin
                len = ($urandom_range(99) < 85) ? $urandom_range(1, 6)
                                                : $urandom_range(7, 40);
                for (int i = 0; i < len; i++)
                    send_pair(pick_word(), pick_word(), i == len - 1);
                sent += len;
            end
            drain();
        end

        if (sb.outstanding() != 0)
        begin
            $error("%0d hashes never arrived", sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== dual_multiply_mix_hash.f =====
hdl/dmmh_pkg.sv
hdl/dmmh_msg_if.sv
hdl/dmmh_hash_if.sv
hdl/dmmh_cfg_if.sv
hdl/dmmh_useq.sv
hdl/dmmh_datapath.sv
hdl/dual_multiply_mix_hash.sv
tb/dual_multiply_mix_hash_test.sv
